### rtl/bmed_pkg.sv
// ----------------------------------------------------------------------------
// Batch median package
// Shared widths, register map, word types and sequencer states.
// ----------------------------------------------------------------------------
package bmed_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int SAMPLE_W       = 16;
    localparam int BIT_W          = $clog2(SAMPLE_W);
    localparam int WSIZE_W        = 6;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET     = 6'd32;
    localparam logic [PADDR_W-1:0] REG_WINDOW_SIZE = 3'd0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } in_word_t;

    typedef struct packed {
        logic                sample_taken;
        logic                full_res;
        logic [SAMPLE_W-1:0] median;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_HOLD
    } state_t;

endpackage

### rtl/bmed_ram.sv
// ----------------------------------------------------------------------------
// Batch median sample RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/batch_median_of_n_core.sv
// ----------------------------------------------------------------------------
// Batch median of N samples
// Collects samples into a window and reports its median once full.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one word per sample (sample, restart). m_ channel returns
//   one word per sample (sample_taken, full_res, median). The user must write
//   window_size via the APB port at offset 0 only while idle (not enforced).
// Operation:
//   While the window is not full after a sample, the result word appears
//   on m_ in the cycle after acceptance. When full, the median is found
//   by a bitwise radix select: 16 passes over the N stored samples, one
//   RAM read and one compare per cycle. The single RAM read port sets the
//   pace of the select, during which s_ready is low.
// Reset:
//   Window is emptied, window_size returns to 32, no result pending.
// Stall:
//   A result waits in the output register; a new sample is taken only when
//   that register is empty or being read in the same cycle.
// ----------------------------------------------------------------------------
module batch_median_of_n_core #(
    parameter int MAX_WINDOW = bmed_pkg::MAX_WINDOW_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  bmed_pkg::in_word_t                s_word,

    output logic                              m_valid,
    input  logic                              m_ready,
    output bmed_pkg::out_word_t               m_word,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bmed_pkg::PADDR_W-1:0]      paddr,
    input  logic [bmed_pkg::PDATA_W-1:0]      pwdata,
    output logic [bmed_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    import bmed_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = (CW > WSIZE_W) ? CW : WSIZE_W;

    state_t              state_reg, state_next;
    logic [WSIZE_W-1:0]  win_size_reg;
    logic [CW-1:0]       fill_reg, fill_next;
    logic                m_valid_reg, m_valid_next;
    out_word_t           m_word_reg, m_word_next;
    logic                taken_reg, taken_next;
    logic [SAMPLE_W-1:0] median_reg, median_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [SAMPLE_W-1:0] prefix_reg, prefix_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    logic                s_fire, out_free;
    logic [SW-1:0]       ws_ext;
    logic [CW-1:0]       size, rank, fill_base, fill_new;
    logic                taken, full_now;
    logic                ram_we;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W:0]   mask_wide;
    logic [SAMPLE_W-1:0] mask, prefix_set;
    logic                hit, pass_end;
    logic [CW-1:0]       cnt_sum;

    // window size saturated to 1..MAX_WINDOW
    assign ws_ext = SW'(win_size_reg);
    always_comb begin
        if (ws_ext == '0) begin
            size = CW'(1);
        end else if (ws_ext > SW'(MAX_WINDOW)) begin
            size = CW'(MAX_WINDOW);
        end else begin
            size = CW'(ws_ext);
        end
    end
    assign rank = size >> 1;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign fill_base = s_word.restart ? '0 : fill_reg;
    assign taken     = fill_base < size;
    assign fill_new  = fill_base + CW'(taken);
    assign full_now  = fill_new >= size;
    assign ram_we    = s_fire && taken;

    bmed_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_base[AW-1:0]),
        .wdata (s_word.sample),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // radix select: count samples matching the prefix above bit with bit clear
    assign mask_wide  = {(SAMPLE_W+1){1'b1}} << ({1'b0, bit_reg} + (BIT_W+1)'(1));
    assign mask       = mask_wide[SAMPLE_W-1:0];
    assign hit        = (idx_reg != '0) && (((ram_rdata ^ prefix_reg) & mask) == '0)
                        && !ram_rdata[bit_reg];
    assign cnt_sum    = cnt_reg + CW'(hit);
    assign pass_end   = idx_reg == size;
    assign prefix_set = prefix_reg | (SAMPLE_W'(1) << bit_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && full_now) begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (pass_end && bit_reg == '0) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready = out_free;
            ST_SELECT: s_ready = 1'b0;
            ST_HOLD:   s_ready = 1'b0;
            default:   s_ready = 1'b0;
        endcase
    end

    always_comb begin
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        taken_next   = taken_reg;
        median_next  = median_reg;
        idx_next     = idx_reg;
        bit_next     = bit_reg;
        prefix_next  = prefix_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    fill_next  = fill_new;
                    taken_next = taken;
                    idx_next   = '0;
                    bit_next   = BIT_W'(SAMPLE_W - 1);
                    prefix_next = '0;
                    rem_next   = rank;
                    cnt_next   = '0;
                    if (!full_now) begin
                        m_word_next.sample_taken = taken;
                        m_word_next.full_res     = 1'b0;
                        m_word_next.median       = '0;
                        m_valid_next             = 1'b1;
                    end
                end
            end
            ST_SELECT: begin
                if (pass_end) begin
                    if (rem_reg >= cnt_sum) begin
                        prefix_next = prefix_set;
                        rem_next    = rem_reg - cnt_sum;
                    end
                    idx_next = '0;
                    cnt_next = '0;
                    bit_next = bit_reg - BIT_W'(1);
                    if (bit_reg == '0) begin
                        median_next = (rem_reg >= cnt_sum) ? prefix_set : prefix_reg;
                    end
                end else begin
                    idx_next = idx_reg + CW'(1);
                    cnt_next = cnt_sum;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_word_next.sample_taken = taken_reg;
                    m_word_next.full_res     = 1'b1;
                    m_word_next.median       = median_reg;
                    m_valid_next             = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
            win_size_reg <= WSIZE_RESET;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (psel && penable && pwrite && pready && paddr == REG_WINDOW_SIZE) begin
                win_size_reg <= pwdata[WSIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        taken_reg  <= taken_next;
        median_reg <= median_next;
        idx_reg    <= idx_next;
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr == REG_WINDOW_SIZE) ? PDATA_W'(win_size_reg) : '0;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(MAX_WINDOW))
        else $error("fill count beyond window depth");

    a_restart_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_word.restart |=> fill_reg == CW'(1))
        else $error("restart did not leave exactly one sample");

    a_median_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.full_res |-> m_word.median == '0)
        else $error("median nonzero while window not full");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.sample_taken |-> m_word.full_res)
        else $error("sample dropped while window not full");

    a_select_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SELECT |-> !s_ready && !ram_we)
        else $error("input taken during median select");

endmodule
